@@ rtl/flsc_pkg.sv @@
// Package: symbol classes, recognizer states and the transition function.
`default_nettype none

package flsc_pkg;

  // Symbol classes: digits '0'..'9' are classes 0..9.
  localparam logic [3:0] ClsDigitMax = 4'd9;
  localparam logic [3:0] ClsZero     = 4'd0;
  localparam logic [3:0] ClsDot      = 4'd10;
  localparam logic [3:0] ClsExp      = 4'd11;
  localparam logic [3:0] ClsPlus     = 4'd12;
  localparam logic [3:0] ClsMinus    = 4'd13;
  localparam logic [3:0] ClsSep      = 4'd14;
  localparam logic [3:0] ClsEnd      = 4'd15;

  // Recognizer states; codes 13..15 are unreachable and behave as reject.
  typedef enum logic [3:0] {
    ST_ACCEPT    = 4'd0,
    ST_REJECT    = 4'd1,
    ST_START     = 4'd2,
    ST_SIGN      = 4'd3,
    ST_ZERO      = 4'd4,
    ST_INT       = 4'd5,
    ST_POINT     = 4'd6,
    ST_FRAC      = 4'd7,
    ST_EXP       = 4'd8,
    ST_EXP_SIGN  = 4'd9,
    ST_EXP_ZERO  = 4'd10,
    ST_EXP_DIGIT = 4'd11,
    ST_SEP       = 4'd12
  } state_e;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    logic       known;  // byte belongs to one of the sixteen classes
    logic [3:0] cls;
    logic       last;
  } cls_word_t;

  // Next state for one classified byte.
  function automatic state_e next_state(input state_e cur, input cls_word_t w);
    state_e nxt;
    logic   digit;
    logic   sign;
    logic   zero;
    digit = (w.cls <= ClsDigitMax);
    zero  = (w.cls == ClsZero);
    sign  = (w.cls == ClsPlus) || (w.cls == ClsMinus);
    nxt   = ST_REJECT;
    if (w.known) begin
      case (cur)
        ST_ACCEPT: begin
          nxt = ST_ACCEPT;
        end
        ST_START: begin
          if (digit)                nxt = zero ? ST_ZERO : ST_INT;
          else if (sign)            nxt = ST_SIGN;
          else if (w.cls == ClsEnd) nxt = ST_ACCEPT;
        end
        ST_SIGN, ST_SEP: begin
          if (digit)      nxt = zero ? ST_ZERO : ST_INT;
          else if (sign)  nxt = (cur == ST_SEP) ? ST_SIGN : ST_REJECT;
        end
        ST_ZERO: begin
          if (w.cls == ClsDot) nxt = ST_POINT;
        end
        ST_INT: begin
          if (digit)                nxt = ST_INT;
          else if (w.cls == ClsDot) nxt = ST_POINT;
        end
        ST_POINT: begin
          if (digit) nxt = ST_FRAC;
        end
        ST_FRAC: begin
          if (digit)                nxt = ST_FRAC;
          else if (w.cls == ClsExp) nxt = ST_EXP;
        end
        ST_EXP, ST_EXP_SIGN: begin
          if (digit)     nxt = zero ? ST_EXP_ZERO : ST_EXP_DIGIT;
          else if (sign) nxt = (cur == ST_EXP) ? ST_EXP_SIGN : ST_REJECT;
        end
        ST_EXP_ZERO, ST_EXP_DIGIT: begin
          if (digit)                nxt = (cur == ST_EXP_DIGIT) ? ST_EXP_DIGIT : ST_REJECT;
          else if (w.cls == ClsSep) nxt = ST_SEP;
          else if (w.cls == ClsEnd) nxt = ST_ACCEPT;
        end
        default: begin
          nxt = ST_REJECT;
        end
      endcase
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/flsc_if.sv @@
// Handshake channels: symbol input and verdict output.
`default_nettype none

interface flsc_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface flsc_res_if;
  logic valid;
  logic ready;
  logic accepted;
  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

`default_nettype wire

@@ rtl/flsc_front.sv @@
// Front end: accept symbol words and classify each byte.
`default_nettype none

module flsc_front
  import flsc_pkg::*;
(
  flsc_sym_if.sink   sym_i,
  output logic       push_valid_o,
  output cls_word_t  push_word_o,
  input  logic       push_ready_i
);

  logic [7:0] sym;
  logic [7:0] dig_off;

  assign sym     = sym_i.symbol;
  assign dig_off = sym - 8'h30;

  // Map the byte to its class; anything else is marked unknown
  always_comb begin
    push_word_o.known = 1'b1;
    push_word_o.cls   = ClsZero;
    push_word_o.last  = sym_i.last;
    if (sym inside {[8'h30:8'h39]}) begin
      push_word_o.cls = dig_off[3:0];
    end else begin
      case (sym)
        8'h2E:   push_word_o.cls = ClsDot;
        8'h45:   push_word_o.cls = ClsExp;
        8'h2B:   push_word_o.cls = ClsPlus;
        8'h2D:   push_word_o.cls = ClsMinus;
        8'h3B:   push_word_o.cls = ClsSep;
        8'h23:   push_word_o.cls = ClsEnd;
        default: push_word_o.known = 1'b0;
      endcase
    end
  end

  // Take a word whenever the queue has room
  assign push_valid_o = sym_i.valid;
  assign sym_i.ready  = push_ready_i;

endmodule

`default_nettype wire

@@ rtl/flsc_queue.sv @@
// Small FIFO between the classifying front end and the recognizer back end.
`default_nettype none

module flsc_queue
  import flsc_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  cls_word_t push_word_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output cls_word_t pop_word_o,
  input  logic      pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  cls_word_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_word_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/flsc_back.sv @@
// Back end: recognizer state machine and registered verdict output.
`default_nettype none

module flsc_back
  import flsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  cls_word_t  pop_word_i,
  output logic       pop_ready_o,
  flsc_res_if.source res_o
);

  state_e state_q, state_d;
  state_e step;
  logic   out_valid_q, out_valid_d;
  logic   out_acc_q, out_acc_d;
  logic   fire;

  // A word that ends a string needs the output slot free or draining
  assign pop_ready_o = !pop_word_i.last || !out_valid_q || res_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;
  assign step        = next_state(state_q, pop_word_i);

  // Advance the state; on the final byte post the verdict and restart
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_acc_d   = out_acc_q;
    if (fire) begin
      if (pop_word_i.last) begin
        state_d     = ST_START;
        out_valid_d = 1'b1;
        out_acc_d   = (step == ST_ACCEPT);
      end else begin
        state_d = step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q <= out_acc_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.accepted = out_acc_q;

endmodule

`default_nettype wire

@@ rtl/float_list_syntax_checker_top.sv @@
// Top level of the decimal float list syntax checker.
//
//   channel | dir | word fields        | accepted when
//   sym_i   | in  | symbol[7:0], last  | valid && ready
//   res_o   | out | accepted           | valid && ready
//
// One byte per cycle is sustained while verdicts are taken. While a verdict
// waits, the back end keeps taking bytes until it meets the next last byte;
// the queue then holds up to QueueDepth bytes before the input stalls.
// A verdict passes the queue, then the output register: its last byte is
// written to the queue, and the verdict loads when the back end pops it.
// Reset clears the queue, the output valid flag and returns the recognizer to
// its start state. No clearing pass is needed.
`default_nettype none

module float_list_syntax_checker_top
  import flsc_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  flsc_sym_if.sink   sym_i,
  flsc_res_if.source res_o
);

  logic      push_valid, push_ready;
  cls_word_t push_word;
  logic      pop_valid, pop_ready;
  cls_word_t pop_word;

  flsc_front u_front (
    .sym_i        (sym_i),
    .push_valid_o (push_valid),
    .push_word_o  (push_word),
    .push_ready_i (push_ready)
  );

  flsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_word_i  (push_word),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_word_o   (pop_word),
    .pop_ready_i  (pop_ready)
  );

  flsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_word_i  (pop_word),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

@@ rtl/flsc_checker.sv @@
// Port-level checks for the syntax checker, bound to the top level.
`default_nettype none

module flsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_accepted
);

  logic [7:0] pend_q;
  logic       in_end;
  logic       out_take;

  assign in_end   = in_valid && in_ready && in_last;
  assign out_take = out_valid && out_ready;

  // Track strings taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {7'd0, in_end} - {7'd0, out_take};
    end
  end

  // Hold a stalled verdict
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted))
    else $error("verdict dropped or changed while stalled");

  // Stay quiet in reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("verdict shown during reset");

  // Every verdict answers an earlier last byte
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 8'd0)
    else $error("verdict without a pending string");

  // Never hold more than 64 pending strings
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 8'd64)
    else $error("pending string count out of range");

endmodule

bind float_list_syntax_checker_top flsc_checker u_flsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (sym_i.valid),
  .in_ready     (sym_i.ready),
  .in_last      (sym_i.last),
  .out_valid    (res_o.valid),
  .out_ready    (res_o.ready),
  .out_accepted (res_o.accepted)
);

`default_nettype wire
